### design/otpc_pkg.sv
// Shared constants for the overlap threshold pair counter.
package otpc_pkg;

    localparam int MAX_RECORDS = 1024;
    localparam int MAX_TOKEN   = 4096;
    localparam int MAX_ENTRIES = 16384;

    localparam int TOK_W  = 12;
    localparam int THR_W  = 12;
    localparam int TOK_AW = $clog2(MAX_TOKEN);
    localparam int REC_AW = $clog2(MAX_RECORDS);
    localparam int ENT_AW = $clog2(MAX_ENTRIES);
    localparam int ECNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int RCNT_W = $clog2(MAX_RECORDS + 1);

    localparam int OVL_W   = 13;
    localparam int OVL_MAX = 8191;
    localparam int PAIR_W  = 19;
    localparam int PAIR_MAX = 524287;

endpackage

### design/otpc_ram.sv
// Generic simple dual port RAM with registered read data.
module otpc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/overlap_threshold_pair_count.sv
// Top level: record loader, inverted index builder and overlap join sequencer.
// Loading: one token request per cycle; in_ready is high only while loading.
// After relation_end: drain, prefix sum of the posting bounds, index fill over all
// records and entries, then per record an overlap count clear and setup, bound reads
// per token and an update per posting; one result, then a posting bound clear.
// Reset (async, active low): a clearing pass over all MAX_TOKEN posting bounds runs
// before the first token is taken; config writes are taken at any time.
module overlap_threshold_pair_count
    import otpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [THR_W-1:0]  overlap_threshold,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TOK_W-1:0]  token,
    input  logic              record_end,
    input  logic              relation_end,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [PAIR_W-1:0] pair_count,
    output logic              capacity_overflow
);

    typedef enum logic [4:0] {
        S_CLR, S_LOAD, S_DRAIN, S_PFX_RD, S_PFX_WR,
        S_FILL_REC, S_FILL_LO, S_FILL_ENT, S_FILL_PB, S_FILL_WR,
        S_JN_REC, S_JN_CLR, S_JN_HI, S_JN_ENT, S_JN_TOK, S_JN_LO, S_JN_HIP,
        S_JN_POST, S_JN_CRD, S_JN_CWR, S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [THR_W-1:0]  thr_reg;
    logic [RCNT_W-1:0] lr_reg, lr_next;
    logic [ECNT_W-1:0] le_reg, le_next;
    logic [PAIR_W-1:0] total_reg, total_next;
    logic              flag_reg, flag_next;
    logic [TOK_AW-1:0] clr_reg, clr_next;
    logic [ECNT_W-1:0] sum_reg, sum_next;
    logic [RCNT_W-1:0] r_reg, r_next;
    logic [ECNT_W-1:0] e_reg, e_next;
    logic [ECNT_W-1:0] bnd_reg, bnd_next;
    logic [TOK_AW-1:0] tok_reg, tok_next;
    logic [ECNT_W-1:0] p_reg, p_next;
    logic [ECNT_W-1:0] plim_reg, plim_next;
    logic [REC_AW-1:0] c_reg, c_next;
    logic [REC_AW-1:0] t_reg, t_next;
    logic              upd_valid_reg, upd_valid_next;
    logic [TOK_AW-1:0] upd_tok_reg, upd_tok_next;
    logic              lw_valid_reg, lw_valid_next;
    logic [TOK_AW-1:0] lw_tok_reg, lw_tok_next;
    logic [ECNT_W-1:0] lw_data_reg, lw_data_next;
    logic              out_valid_reg, out_valid_next;
    logic [PAIR_W-1:0] pair_count_reg, pair_count_next;
    logic              ovf_reg, ovf_next;

    logic              ts_we, rb_we, ps_we, pb_we, ct_we;
    logic [ENT_AW-1:0] ts_waddr, ts_raddr, ps_waddr, ps_raddr;
    logic [TOK_W-1:0]  ts_wdata, ts_q;
    logic [REC_AW-1:0] rb_waddr, rb_raddr, ct_waddr, ct_raddr;
    logic [ECNT_W-1:0] rb_wdata, rb_q;
    logic [REC_AW-1:0] ps_wdata, ps_q;
    logic [TOK_AW-1:0] pb_waddr, pb_raddr;
    logic [ECNT_W-1:0] pb_wdata, pb_q;
    logic [OVL_W-1:0]  ct_wdata, ct_q;

    logic              accept, drop;
    logic [ECNT_W-1:0] le_new, base;
    logic [OVL_W-1:0]  ovl_new;

    otpc_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(TOK_W)) u_tok_store (
        .clk(clk), .we(ts_we), .waddr(ts_waddr), .wdata(ts_wdata),
        .raddr(ts_raddr), .rdata(ts_q)
    );
    otpc_ram #(.DEPTH(MAX_RECORDS), .WIDTH(ECNT_W)) u_rec_bounds (
        .clk(clk), .we(rb_we), .waddr(rb_waddr), .wdata(rb_wdata),
        .raddr(rb_raddr), .rdata(rb_q)
    );
    otpc_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(REC_AW)) u_post_store (
        .clk(clk), .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
        .raddr(ps_raddr), .rdata(ps_q)
    );
    otpc_ram #(.DEPTH(MAX_TOKEN), .WIDTH(ECNT_W)) u_post_bounds (
        .clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
        .raddr(pb_raddr), .rdata(pb_q)
    );
    otpc_ram #(.DEPTH(MAX_RECORDS), .WIDTH(OVL_W)) u_ovl_counts (
        .clk(clk), .we(ct_we), .waddr(ct_waddr), .wdata(ct_wdata),
        .raddr(ct_raddr), .rdata(ct_q)
    );

    assign cfg_ready         = 1'b1;
    assign in_ready          = (state_reg == S_LOAD);
    assign out_valid         = out_valid_reg;
    assign pair_count        = pair_count_reg;
    assign capacity_overflow = ovf_reg;
    assign accept            = in_valid && in_ready;

    always_comb
    begin
        state_next      = state_reg;
        lr_next         = lr_reg;
        le_next         = le_reg;
        total_next      = total_reg;
        flag_next       = flag_reg;
        clr_next        = clr_reg;
        sum_next        = sum_reg;
        r_next          = r_reg;
        e_next          = e_reg;
        bnd_next        = bnd_reg;
        tok_next        = tok_reg;
        p_next          = p_reg;
        plim_next       = plim_reg;
        c_next          = c_reg;
        t_next          = t_reg;
        upd_valid_next  = 1'b0;
        upd_tok_next    = upd_tok_reg;
        lw_valid_next   = 1'b0;
        lw_tok_next     = lw_tok_reg;
        lw_data_next    = lw_data_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        pair_count_next = pair_count_reg;
        ovf_next        = ovf_reg;

        ts_we = 1'b0; ts_waddr = le_reg[ENT_AW-1:0]; ts_wdata = token;
        ts_raddr = e_reg[ENT_AW-1:0];
        rb_we = 1'b0; rb_waddr = lr_reg[REC_AW-1:0];
        rb_raddr = r_reg[REC_AW-1:0];
        ps_we = 1'b0; ps_waddr = p_reg[ENT_AW-1:0]; ps_wdata = t_reg;
        ps_raddr = p_reg[ENT_AW-1:0];
        pb_we = 1'b0; pb_waddr = clr_reg; pb_wdata = '0;
        pb_raddr = token[TOK_AW-1:0];
        ct_we = 1'b0; ct_waddr = c_reg; ct_wdata = '0;
        ct_raddr = c_reg;

        drop    = (int'(lr_reg) >= MAX_RECORDS) || (int'(le_reg) >= MAX_ENTRIES)
                  || (int'(token) >= MAX_TOKEN);
        le_new  = drop ? le_reg : le_reg + 1'b1;
        rb_wdata = le_new;
        base    = (lw_valid_reg && lw_tok_reg == upd_tok_reg) ? lw_data_reg : pb_q;
        ovl_new = (ct_q == OVL_W'(OVL_MAX)) ? ct_q : ct_q + 1'b1;

        // pending posting count update from the previous accepted token
        if (upd_valid_reg)
        begin
            pb_we         = 1'b1;
            pb_waddr      = upd_tok_reg;
            pb_wdata      = base + 1'b1;
            lw_valid_next = 1'b1;
            lw_tok_next   = upd_tok_reg;
            lw_data_next  = base + 1'b1;
        end

        case (state_reg)
            S_CLR:
            begin
                pb_we    = 1'b1;
                pb_waddr = clr_reg;
                pb_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == TOK_AW'(MAX_TOKEN - 1))
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (accept)
                begin
                    if (drop)
                    begin
                        flag_next = 1'b1;
                    end
                    else
                    begin
                        ts_we          = 1'b1;
                        upd_valid_next = 1'b1;
                        upd_tok_next   = token[TOK_AW-1:0];
                    end
                    le_next = le_new;
                    if ((record_end || relation_end) && int'(lr_reg) < MAX_RECORDS)
                    begin
                        rb_we   = 1'b1;
                        lr_next = lr_reg + 1'b1;
                    end
                    if (relation_end)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                clr_next   = '0;
                sum_next   = '0;
                state_next = S_PFX_RD;
            end
            S_PFX_RD:
            begin
                pb_raddr   = clr_reg;
                state_next = S_PFX_WR;
            end
            S_PFX_WR:
            begin
                sum_next = sum_reg + pb_q;
                pb_we    = 1'b1;
                pb_waddr = clr_reg;
                pb_wdata = sum_reg + pb_q;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == TOK_AW'(MAX_TOKEN - 1))
                begin
                    r_next     = lr_reg;
                    e_next     = le_reg;
                    state_next = S_FILL_REC;
                end
                else
                begin
                    state_next = S_PFX_RD;
                end
            end
            S_FILL_REC:
            begin
                rb_raddr = REC_AW'(r_reg - 2'd2);
                if (r_reg == '0)
                begin
                    r_next     = '0;
                    e_next     = '0;
                    state_next = S_JN_REC;
                end
                else
                begin
                    state_next = S_FILL_LO;
                end
            end
            S_FILL_LO:
            begin
                bnd_next   = (r_reg >= RCNT_W'(2)) ? rb_q : '0;
                state_next = S_FILL_ENT;
            end
            S_FILL_ENT:
            begin
                ts_raddr = ENT_AW'(e_reg - 1'b1);
                if (e_reg == bnd_reg)
                begin
                    r_next     = r_reg - 1'b1;
                    state_next = S_FILL_REC;
                end
                else
                begin
                    e_next     = e_reg - 1'b1;
                    state_next = S_FILL_PB;
                end
            end
            S_FILL_PB:
            begin
                pb_raddr   = ts_q[TOK_AW-1:0];
                tok_next   = ts_q[TOK_AW-1:0];
                state_next = S_FILL_WR;
            end
            S_FILL_WR:
            begin
                pb_we      = 1'b1;
                pb_waddr   = tok_reg;
                pb_wdata   = pb_q - 1'b1;
                ps_we      = 1'b1;
                ps_waddr   = ENT_AW'(pb_q - 1'b1);
                ps_wdata   = REC_AW'(r_reg - 1'b1);
                state_next = S_FILL_ENT;
            end
            S_JN_REC:
            begin
                c_next = '0;
                if (r_reg == lr_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_JN_CLR;
                end
            end
            S_JN_CLR:
            begin
                ct_we    = 1'b1;
                ct_waddr = c_reg;
                ct_wdata = '0;
                rb_raddr = r_reg[REC_AW-1:0];
                c_next   = c_reg + 1'b1;
                if ({1'b0, c_reg} == RCNT_W'(lr_reg - 1'b1))
                begin
                    state_next = S_JN_HI;
                end
            end
            S_JN_HI:
            begin
                bnd_next   = rb_q;
                state_next = S_JN_ENT;
            end
            S_JN_ENT:
            begin
                ts_raddr = e_reg[ENT_AW-1:0];
                if (e_reg == bnd_reg)
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = S_JN_REC;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = S_JN_TOK;
                end
            end
            S_JN_TOK:
            begin
                tok_next   = ts_q[TOK_AW-1:0];
                pb_raddr   = ts_q[TOK_AW-1:0];
                state_next = S_JN_LO;
            end
            S_JN_LO:
            begin
                p_next   = pb_q;
                pb_raddr = tok_reg + 1'b1;
                if (tok_reg == TOK_AW'(MAX_TOKEN - 1))
                begin
                    plim_next  = le_reg;
                    state_next = S_JN_POST;
                end
                else
                begin
                    state_next = S_JN_HIP;
                end
            end
            S_JN_HIP:
            begin
                plim_next  = pb_q;
                state_next = S_JN_POST;
            end
            S_JN_POST:
            begin
                ps_raddr = p_reg[ENT_AW-1:0];
                if (p_reg == plim_reg)
                begin
                    state_next = S_JN_ENT;
                end
                else
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = S_JN_CRD;
                end
            end
            S_JN_CRD:
            begin
                t_next     = ps_q;
                ct_raddr   = ps_q;
                state_next = S_JN_CWR;
            end
            S_JN_CWR:
            begin
                ct_we    = 1'b1;
                ct_waddr = t_reg;
                ct_wdata = ovl_new;
                if ({1'b0, t_reg} > r_reg && ovl_new == {1'b0, thr_reg}
                    && total_reg != PAIR_W'(PAIR_MAX))
                begin
                    total_next = total_reg + 1'b1;
                end
                state_next = S_JN_POST;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    pair_count_next = total_reg;
                    ovf_next        = flag_reg;
                    lr_next         = '0;
                    le_next         = '0;
                    total_next      = '0;
                    flag_next       = 1'b0;
                    clr_next        = '0;
                    state_next      = S_CLR;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            thr_reg       <= THR_W'(1);
            lr_reg        <= '0;
            le_reg        <= '0;
            total_reg     <= '0;
            flag_reg      <= 1'b0;
            clr_reg       <= '0;
            r_reg         <= '0;
            e_reg         <= '0;
            upd_valid_reg <= 1'b0;
            lw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_valid)
            begin
                thr_reg <= overlap_threshold;
            end
            lr_reg        <= lr_next;
            le_reg        <= le_next;
            total_reg     <= total_next;
            flag_reg      <= flag_next;
            clr_reg       <= clr_next;
            r_reg         <= r_next;
            e_reg         <= e_next;
            upd_valid_reg <= upd_valid_next;
            lw_valid_reg  <= lw_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg        <= sum_next;
        bnd_reg        <= bnd_next;
        tok_reg        <= tok_next;
        p_reg          <= p_next;
        plim_reg       <= plim_next;
        c_reg          <= c_next;
        t_reg          <= t_next;
        upd_tok_reg    <= upd_tok_next;
        lw_tok_reg     <= lw_tok_next;
        lw_data_reg    <= lw_data_next;
        pair_count_reg <= pair_count_next;
        ovf_reg        <= ovf_next;
    end

`ifndef SYNTHESIS
    a_rec_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(lr_reg) <= MAX_RECORDS)
        else $error("record count beyond capacity");

    a_ent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(le_reg) <= MAX_ENTRIES)
        else $error("entry count beyond capacity");

    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_OUT) |=> (total_reg >= $past(total_reg)))
        else $error("pair total decreased during join");

    a_upd_phase: assert property (@(posedge clk) disable iff (!rst_n)
        upd_valid_reg |-> (state_reg == S_LOAD || state_reg == S_DRAIN))
        else $error("count update outside load");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside output step");
`endif

endmodule

### tb/otpc_checker.sv
// Checker for the overlap threshold pair counter: predicts each pair count and overflow flag and compares.
`timescale 1ns / 100ps

module otpc_checker
    import otpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [THR_W-1:0]  overlap_threshold,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [TOK_W-1:0]  token,
    input  logic              record_end,
    input  logic              relation_end,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [PAIR_W-1:0] pair_count,
    input  logic              capacity_overflow,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic [PAIR_W-1:0] pairs;
        logic              ovf;
    } join_result_t;

    logic [TOK_W-1:0] tok_mem [MAX_ENTRIES];
    int               rec_bound [MAX_RECORDS];
    int               n_ent;
    int               n_rec;
    logic             ovf_seen;
    logic [THR_W-1:0] thr;
    join_result_t     join_q [$];

    // pair (i, j) counts once the overlap counter of j reaches thr while scanning i
    function automatic logic [PAIR_W-1:0] count_pairs();
        int total;
        int ovl;
        int lo_i;
        int lo_j;
        total = 0;
        for (int i = 0; i < n_rec; i++)
        begin
            lo_i = (i == 0) ? 0 : rec_bound[i-1];
            for (int j = i + 1; j < n_rec; j++)
            begin
                lo_j = rec_bound[j-1];
                ovl = 0;
                for (int a = lo_i; a < rec_bound[i]; a++)
                    for (int b = lo_j; b < rec_bound[j]; b++)
                        if (tok_mem[a] == tok_mem[b] && ovl < OVL_MAX)
                            ovl++;
                if (thr != 0 && ovl >= thr && total < PAIR_MAX)
                    total++;
            end
        end
        return total[PAIR_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        join_result_t got;
        join_result_t exp_r;
        if (!rst_n)
        begin
            n_ent      = 0;
            n_rec      = 0;
            ovf_seen   = 1'b0;
            thr        = 1;
            fail_count = 0;
            pending    = 0;
            join_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                thr = overlap_threshold;
            if (in_valid && in_ready)
            begin
                if (n_rec >= MAX_RECORDS || n_ent >= MAX_ENTRIES)
                    ovf_seen = 1'b1;
                else
                begin
                    tok_mem[n_ent] = token;
                    n_ent++;
                end
                if ((record_end || relation_end) && n_rec < MAX_RECORDS)
                begin
                    rec_bound[n_rec] = n_ent;
                    n_rec++;
                end
                if (relation_end)
                begin
                    exp_r.pairs = count_pairs();
                    exp_r.ovf   = ovf_seen;
                    join_q.push_back(exp_r);
                    n_ent    = 0;
                    n_rec    = 0;
                    ovf_seen = 1'b0;
                end
            end
            if (out_valid && out_ready)
            begin
                got.pairs = pair_count;
                got.ovf   = capacity_overflow;
                if (join_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual pairs %0d ovf %0b",
                             $time, got.pairs, got.ovf);
                    fail_count++;
                end
                else
                begin
                    exp_r = join_q.pop_front();
                    if (got.pairs !== exp_r.pairs)
                    begin
                        $display("%0t: pair_count mismatch, expected %0d, actual %0d",
                                 $time, exp_r.pairs, got.pairs);
                        fail_count++;
                    end
                    if (got.ovf !== exp_r.ovf)
                    begin
                        $display("%0t: capacity_overflow mismatch, expected %0b, actual %0b",
                                 $time, exp_r.ovf, got.ovf);
                        fail_count++;
                    end
                end
            end
            pending = join_q.size();
        end
    end

endmodule

### tb/overlap_threshold_pair_count_tb.sv
// Testbench top for the overlap threshold pair counter: stimulus, idling and verdict.
`timescale 1ns / 100ps

module overlap_threshold_pair_count_tb;
    import otpc_pkg::*;

    localparam int IDLE_LIMIT  = 4000000;
    localparam int CLEAR_WAIT  = MAX_TOKEN + 200;
    localparam int RAND_TOKENS = 600;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [THR_W-1:0]  overlap_threshold;
    logic              in_valid;
    logic              in_ready;
    logic [TOK_W-1:0]  token;
    logic              record_end;
    logic              relation_end;
    logic              out_valid;
    logic              out_ready;
    logic [PAIR_W-1:0] pair_count;
    logic              capacity_overflow;
    int                fail_count;
    int                pending;
    bit                gaps_on;
    int                stall_left;
    int                idle_cycles;
    int                sent;

    overlap_threshold_pair_count i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .overlap_threshold (overlap_threshold),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .token             (token),
        .record_end        (record_end),
        .relation_end      (relation_end),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .pair_count        (pair_count),
        .capacity_overflow (capacity_overflow)
    );

    otpc_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .overlap_threshold (overlap_threshold),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .token             (token),
        .record_end        (record_end),
        .relation_end      (relation_end),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .pair_count        (pair_count),
        .capacity_overflow (capacity_overflow),
        .fail_count        (fail_count),
        .pending           (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 3);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // pending is sampled away from the rising edge so the checker has settled
    task automatic wait_drained();
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (CLEAR_WAIT) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        wait_drained();
        cfg_valid         <= 1'b1;
        overlap_threshold <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_token(input logic [TOK_W-1:0] tok, input logic rec_e,
                              input logic rel_e);
        int n;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid     <= 1'b1;
        token        <= tok;
        record_end   <= rec_e;
        relation_end <= rel_e;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        sent++;
    endtask

    task automatic end_request();
        in_valid <= 1'b0;
    endtask

    initial
    begin
        int n_rec;
        int len;
        int pool;
        logic [TOK_W-1:0] t;
        rst_n             = 1'b0;
        cfg_valid         = 1'b0;
        overlap_threshold = '0;
        in_valid          = 1'b0;
        token             = '0;
        record_end        = 1'b0;
        relation_end      = 1'b0;
        out_ready         = 1'b0;
        stall_left        = 0;
        idle_cycles       = 0;
        sent              = 0;
        gaps_on           = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default threshold, extreme tokens, token zero
        send_token(12'd5, 1'b0, 1'b0);
        send_token(12'd4095, 1'b1, 1'b0);
        send_token(12'd5, 1'b0, 1'b0);
        send_token(12'd6, 1'b1, 1'b0);
        send_token(12'd0, 1'b0, 1'b0);
        send_token(12'd4095, 1'b1, 1'b1);
        // relation of one token, closed by relation_end alone
        send_token(12'd2730, 1'b0, 1'b1);
        // relation_end closes an open record
        send_token(12'd1365, 1'b1, 1'b0);
        send_token(12'd1365, 1'b0, 1'b1);
        end_request();
        // repeated tokens in a record
        write_threshold(12'd2);
        send_token(12'd7, 1'b0, 1'b0);
        send_token(12'd7, 1'b1, 1'b0);
        send_token(12'd7, 1'b1, 1'b0);
        send_token(12'd8, 1'b0, 1'b0);
        send_token(12'd7, 1'b1, 1'b1);
        end_request();
        write_threshold(12'd4095);
        send_token(12'd9, 1'b1, 1'b0);
        send_token(12'd9, 1'b1, 1'b1);
        end_request();
        // record store full: distinct tokens, one per record
        write_threshold(12'd1);
        for (int r = 0; r < MAX_RECORDS + 6; r++)
            send_token(TOK_W'(r + 1), 1'b1, r == MAX_RECORDS + 5);
        end_request();
        wait_drained();

        while (sent < MAX_RECORDS + 30 + RAND_TOKENS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 5))
                    0: write_threshold(12'd4095);
                    1: write_threshold(12'd3);
                    2: write_threshold(THR_W'($urandom_range(1, 4095)));
                    default: write_threshold(12'd1);
                endcase
            end
            if (sent > MAX_RECORDS + 30 + RAND_TOKENS * 85 / 100)
                gaps_on = 1'b0;
            n_rec = $urandom_range(1, 8);
            pool  = ($urandom_range(0, 4) == 0) ? 4095 : $urandom_range(2, 12);
            for (int r = 0; r < n_rec; r++)
            begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                begin
                    t = TOK_W'($urandom_range(0, pool));
                    if ($urandom_range(0, 9) == 0)
                        send_token(t, 1'($urandom_range(0, 1)), 1'b0);
                    else
                        send_token(t, k == len - 1, (r == n_rec - 1) && (k == len - 1));
                end
            end
            end_request();
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        wait_drained();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### overlap_threshold_pair_count.f
design/otpc_pkg.sv
design/otpc_ram.sv
design/overlap_threshold_pair_count.sv
tb/otpc_checker.sv
tb/overlap_threshold_pair_count_tb.sv
